[hdl/htt_pkg.sv]
// Shared types and constants for the HTML tag/text tokenizer.
package htt_pkg;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [15:0] DASH_DASH = {CH_DASH, CH_DASH};

    typedef enum logic [2:0] {
        KIND_TEXT    = 3'd0,
        KIND_OPEN    = 3'd1,
        KIND_CONTENT = 3'd2,
        KIND_CLOSE   = 3'd3,
        KIND_IGNORED = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CHK_NONE = 3'd0,
        CHK_E0   = 3'd1,
        CHK_ED   = 3'd2,
        CHK_F0   = 3'd3,
        CHK_F4   = 3'd4
    } chk_t;

    typedef enum logic [2:0] {
        NM_START   = 3'd0,
        NM_SLASH   = 3'd1,
        NM_BANG    = 3'd2,
        NM_DASH1   = 3'd3,
        NM_DASH2   = 3'd4,
        NM_COMMENT = 3'd5,
        NM_OTHER   = 3'd6
    } nm_state_t;

    typedef struct packed {
        logic        inside_tag;
        logic [1:0]  utf8_remaining;
        chk_t        utf8_check;
        nm_state_t   name_match;
        logic [15:0] recent_tag_bytes;
        logic        text_pending;
        logic        error_latch;
    } lex_state_t;

    localparam lex_state_t LEX_STATE_RESET = '{
        inside_tag:       1'b0,
        utf8_remaining:   2'd0,
        utf8_check:       CHK_NONE,
        name_match:       NM_START,
        recent_tag_bytes: 16'h0000,
        text_pending:     1'b0,
        error_latch:      1'b0
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       utf8_error;
        logic       tail_dropped;
    } out_item_t;

endpackage

[hdl/htt_if.sv]
// Valid/ready stream interfaces for the input bytes and the result items.
interface htt_in_if
    import htt_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface htt_out_if
    import htt_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hdl/htt_step.sv]
// Per-byte next-state and result logic of the tokenizer.
module htt_step
    import htt_pkg::*;
(
    input  lex_state_t st,
    input  in_item_t   item,
    output lex_state_t st_next,
    output out_item_t  result
);

    function automatic nm_state_t name_step(input nm_state_t s, input logic [7:0] b);
        logic alnum;
        nm_state_t r;
        alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                (b >= 8'h61 && b <= 8'h7A);
        unique case (s)
            NM_START:   r = (b == CH_SLASH) ? NM_SLASH : ((b == CH_BANG) ? NM_BANG : NM_OTHER);
            NM_SLASH:   r = (b == CH_BANG) ? NM_BANG : NM_OTHER;
            NM_BANG:    r = (b == CH_DASH) ? NM_DASH1 : NM_OTHER;
            NM_DASH1:   r = (b == CH_DASH) ? NM_DASH2 : NM_OTHER;
            NM_DASH2:   r = (alnum || b == CH_DASH) ? NM_OTHER : NM_COMMENT;
            NM_COMMENT: r = NM_COMMENT;
            NM_OTHER:   r = NM_OTHER;
            default:    r = NM_OTHER;
        endcase
        return r;
    endfunction

    logic [7:0]  b;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        ok;
    logic [1:0]  rem_n;
    chk_t        chk_n;
    kind_t       kind;
    logic        tail;
    lex_state_t  n;

    assign b = item.data_byte;

    always_comb
    begin
        lo    = 8'h80;
        hi    = 8'hBF;
        ok    = 1'b0;
        rem_n = st.utf8_remaining;
        chk_n = st.utf8_check;
        unique case (st.utf8_check)
            CHK_E0:  lo = 8'hA0;
            CHK_ED:  hi = 8'h9F;
            CHK_F0:  lo = 8'h90;
            CHK_F4:  hi = 8'h8F;
            default: ;
        endcase
        if (st.utf8_remaining != 2'd0)
        begin
            ok = (b >= lo) && (b <= hi);
            chk_n = CHK_NONE;
            rem_n = st.utf8_remaining - 2'd1;
        end
        else if (b < 8'h80)
        begin
            ok = 1'b1;
        end
        else if (b >= 8'hC2 && b <= 8'hDF)
        begin
            ok = 1'b1;
            rem_n = 2'd1;
            chk_n = CHK_NONE;
        end
        else if (b >= 8'hE0 && b <= 8'hEF)
        begin
            ok = 1'b1;
            rem_n = 2'd2;
            chk_n = (b == 8'hE0) ? CHK_E0 : ((b == 8'hED) ? CHK_ED : CHK_NONE);
        end
        else if (b >= 8'hF0 && b <= 8'hF4)
        begin
            ok = 1'b1;
            rem_n = 2'd3;
            chk_n = (b == 8'hF0) ? CHK_F0 : ((b == 8'hF4) ? CHK_F4 : CHK_NONE);
        end
    end

    always_comb
    begin
        n    = st;
        kind = KIND_IGNORED;
        tail = 1'b0;
        if (!st.error_latch)
        begin
            if (!ok)
            begin
                n.error_latch = 1'b1;
            end
            else
            begin
                n.utf8_remaining = rem_n;
                n.utf8_check     = chk_n;
                if (b == CH_LT && !st.inside_tag)
                begin
                    n.inside_tag       = 1'b1;
                    n.name_match       = NM_START;
                    n.recent_tag_bytes = 16'h0000;
                    n.text_pending     = 1'b0;
                    kind               = KIND_OPEN;
                end
                else if (!st.inside_tag)
                begin
                    n.text_pending = 1'b1;
                    kind           = KIND_TEXT;
                end
                else if (b == CH_GT && !((st.name_match == NM_DASH2 ||
                         st.name_match == NM_COMMENT) && st.recent_tag_bytes != DASH_DASH))
                begin
                    n.inside_tag   = 1'b0;
                    n.text_pending = 1'b0;
                    kind           = KIND_CLOSE;
                end
                else
                begin
                    n.name_match       = name_step(st.name_match, b);
                    n.recent_tag_bytes = {st.recent_tag_bytes[7:0], b};
                    kind               = KIND_CONTENT;
                end
            end
        end
        if (item.last_byte)
        begin
            if (!n.error_latch && n.utf8_remaining != 2'd0)
            begin
                n.error_latch = 1'b1;
            end
            tail = !n.error_latch && (n.inside_tag || n.text_pending);
        end
        result.out_byte     = b;
        result.kind         = n.error_latch ? KIND_IGNORED : kind;
        result.utf8_error   = n.error_latch;
        result.tail_dropped = tail;
        st_next             = item.last_byte ? LEX_STATE_RESET : n;
    end

endmodule

[hdl/html_tag_text_tokenizer_top.sv]
// Throughput: one byte per cycle while the output is free; the input register, the per-byte
// step logic and the output register form a two-stage pipeline that advances whenever the
// output is free.
// Reset: rst_n clears both valid flags and returns the lexer state to the start of a
// document; the lexer state also returns to that point after each last byte.
module html_tag_text_tokenizer_top
    import htt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    htt_in_if.sink           byte_stream,
    htt_out_if.source        token_stream
);

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    lex_state_t state_reg;
    lex_state_t state_next;
    out_item_t  step_result;
    logic       advance;
    logic       take;

    assign advance = in_valid_reg && (!out_valid_reg || token_stream.ready);
    assign byte_stream.ready = !in_valid_reg || advance;
    assign take = byte_stream.valid && byte_stream.ready;

    htt_step u_step (
        .st      (state_reg),
        .item    (in_item_reg),
        .st_next (state_next),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= LEX_STATE_RESET;
        end
        else
        begin
            if (byte_stream.ready)
            begin
                in_valid_reg <= byte_stream.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (token_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= byte_stream.payload;
        end
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    assign token_stream.valid   = out_valid_reg;
    assign token_stream.payload = out_item_reg;

    // A free output register never holds back the input side.
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> byte_stream.ready)
        else $error("input stalled while output register is empty");

    // A latched UTF-8 error persists until the end of the document.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg.error_latch && !in_item_reg.last_byte |=> state_reg.error_latch)
        else $error("error latch cleared inside a document");

    // The last byte of a document leaves the lexer at its start state.
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.last_byte |=> state_reg == LEX_STATE_RESET)
        else $error("state not reset after last byte");

    // A range check on a continuation byte only exists for three- and four-byte forms.
    a_chk_needs_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.utf8_check != CHK_NONE |-> state_reg.utf8_remaining >= 2'd2)
        else $error("continuation range check without pending bytes");

    // A dropped tail is only reported on an error-free result.
    a_tail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.tail_dropped |-> !out_item_reg.utf8_error)
        else $error("tail dropped flagged together with an error");

endmodule

[bench/html_tag_text_tokenizer_top_tb.sv]
// Self-checking testbench for the HTML tag/text tokenizer with directed and random documents.
`timescale 1ns / 1ps

module html_tag_text_tokenizer_top_tb;
    import htt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;

    htt_in_if  byte_stream ();
    htt_out_if token_stream ();

    html_tag_text_tokenizer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_stream),
        .token_stream (token_stream)
    );

    // Lexer state kept by the predictor.
    logic        in_tag;
    logic [1:0]  cont_left;
    chk_t        cont_check;
    nm_state_t   name_st;
    logic [15:0] tag_tail;
    logic        have_text;
    logic        bad_doc;

    out_item_t   pending_tokens[$];
    logic [7:0]  doc_bytes[$];

    int send_idle_pct = 33;
    int recv_idle_pct = 73;
    int hold_left = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int docs_sent = 0;
    int tokens_checked = 0;
    int error_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_lexer();
        in_tag     = 1'b0;
        cont_left  = 2'd0;
        cont_check = CHK_NONE;
        name_st    = NM_START;
        tag_tail   = 16'h0000;
        have_text  = 1'b0;
        bad_doc    = 1'b0;
    endfunction

    function automatic bit is_word_char(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic bit utf8_ok(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (cont_left != 2'd0)
        begin
            case (cont_check)
                CHK_E0: lo = 8'hA0;
                CHK_ED: hi = 8'h9F;
                CHK_F0: lo = 8'h90;
                CHK_F4: hi = 8'h8F;
                default: ;
            endcase
            if (b < lo || b > hi)
                return 1'b0;
            cont_check = CHK_NONE;
            cont_left  = cont_left - 2'd1;
            return 1'b1;
        end
        if (b < 8'h80)
            return 1'b1;
        if (b >= 8'hC2 && b <= 8'hDF)
        begin
            cont_left  = 2'd1;
            cont_check = CHK_NONE;
            return 1'b1;
        end
        if (b >= 8'hE0 && b <= 8'hEF)
        begin
            cont_left = 2'd2;
            if (b == 8'hE0)
                cont_check = CHK_E0;
            else if (b == 8'hED)
                cont_check = CHK_ED;
            else
                cont_check = CHK_NONE;
            return 1'b1;
        end
        if (b >= 8'hF0 && b <= 8'hF4)
        begin
            cont_left = 2'd3;
            if (b == 8'hF0)
                cont_check = CHK_F0;
            else if (b == 8'hF4)
                cont_check = CHK_F4;
            else
                cont_check = CHK_NONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void tag_push(input logic [7:0] b);
        case (name_st)
            NM_START:
                if (b == CH_SLASH)
                    name_st = NM_SLASH;
                else if (b == CH_BANG)
                    name_st = NM_BANG;
                else
                    name_st = NM_OTHER;
            NM_SLASH:
                if (b == CH_BANG)
                    name_st = NM_BANG;
                else
                    name_st = NM_OTHER;
            NM_BANG:
                if (b == CH_DASH)
                    name_st = NM_DASH1;
                else
                    name_st = NM_OTHER;
            NM_DASH1:
                if (b == CH_DASH)
                    name_st = NM_DASH2;
                else
                    name_st = NM_OTHER;
            NM_DASH2:
                if (is_word_char(b) || b == CH_DASH)
                    name_st = NM_OTHER;
                else
                    name_st = NM_COMMENT;
            NM_COMMENT: ;
            default:
                name_st = NM_OTHER;
        endcase
        tag_tail = {tag_tail[7:0], b};
    endfunction

    function automatic out_item_t predict_token(input logic [7:0] b, input logic last);
        out_item_t tok;
        kind_t     k;
        logic      tail;
        k    = KIND_IGNORED;
        tail = 1'b0;
        if (!bad_doc)
        begin
            if (!utf8_ok(b))
                bad_doc = 1'b1;
            else if (b == CH_LT)
            begin
                if (in_tag)
                begin
                    tag_push(b);
                    k = KIND_CONTENT;
                end
                else
                begin
                    in_tag    = 1'b1;
                    name_st   = NM_START;
                    tag_tail  = 16'h0000;
                    have_text = 1'b0;
                    k         = KIND_OPEN;
                end
            end
            else if (b == CH_GT)
            begin
                if (!in_tag)
                begin
                    have_text = 1'b1;
                    k         = KIND_TEXT;
                end
                else if ((name_st == NM_DASH2 || name_st == NM_COMMENT) &&
                         tag_tail != DASH_DASH)
                begin
                    tag_push(b);
                    k = KIND_CONTENT;
                end
                else
                begin
                    in_tag    = 1'b0;
                    have_text = 1'b0;
                    k         = KIND_CLOSE;
                end
            end
            else if (in_tag)
            begin
                tag_push(b);
                k = KIND_CONTENT;
            end
            else
            begin
                have_text = 1'b1;
                k         = KIND_TEXT;
            end
        end
        if (last)
        begin
            if (!bad_doc && cont_left != 2'd0)
            begin
                bad_doc = 1'b1;
                k       = KIND_IGNORED;
            end
            if (!bad_doc && (in_tag || have_text))
                tail = 1'b1;
        end
        tok.out_byte     = b;
        tok.kind         = bad_doc ? KIND_IGNORED : k;
        tok.utf8_error   = bad_doc;
        tok.tail_dropped = tail;
        if (last)
            clear_lexer();
        return tok;
    endfunction

    function automatic void note_error(input string msg);
        if (error_count < 10)
            $display("ERROR: %s", msg);
        error_count++;
    endfunction

    // Predicts on every accepted byte and checks every accepted token.
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            if (byte_stream.valid && byte_stream.ready)
                pending_tokens.push_back(predict_token(byte_stream.payload.data_byte,
                                                       byte_stream.payload.last_byte));
            if (token_stream.valid && token_stream.ready)
            begin
                got = token_stream.payload;
                if (pending_tokens.size() == 0)
                    note_error($sformatf("unexpected token byte %h kind %0d",
                                         got.out_byte, got.kind));
                else
                begin
                    want = pending_tokens.pop_front();
                    if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                        got.utf8_error !== want.utf8_error ||
                        got.tail_dropped !== want.tail_dropped)
                        note_error($sformatf({"token %0d: expected byte %h kind %0d err %b ",
                                              "tail %b, got byte %h kind %0d err %b tail %b"},
                                             tokens_checked, want.out_byte, want.kind,
                                             want.utf8_error, want.tail_dropped, got.out_byte,
                                             got.kind, got.utf8_error, got.tail_dropped));
                end
                tokens_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            token_stream.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            token_stream.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        in_item_t item;
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            byte_stream.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
        item.data_byte = b;
        item.last_byte = last;
        byte_stream.valid   <= 1'b1;
        byte_stream.payload <= item;
        do
            @(posedge clk);
        while (!byte_stream.ready);
        bytes_sent++;
        if (last)
            docs_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic drain_tokens();
        byte_stream.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_tokens.size() != 0);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        drain_tokens();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(posedge clk);
    endtask

    function automatic void add_char();
        logic [7:0] lead;
        case ($urandom_range(9, 0))
            6:
            begin
                doc_bytes.push_back(8'($urandom_range(8'hDF, 8'hC2)));
                doc_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end
            7:
            begin
                lead = 8'($urandom_range(8'hEF, 8'hE0));
                doc_bytes.push_back(lead);
                if (lead == 8'hE0)
                    doc_bytes.push_back(8'($urandom_range(8'hBF, 8'hA0)));
                else if (lead == 8'hED)
                    doc_bytes.push_back(8'($urandom_range(8'h9F, 8'h80)));
                else
                    doc_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
                doc_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end
            8:
            begin
                lead = 8'($urandom_range(8'hF4, 8'hF0));
                doc_bytes.push_back(lead);
                if (lead == 8'hF0)
                    doc_bytes.push_back(8'($urandom_range(8'hBF, 8'h90)));
                else if (lead == 8'hF4)
                    doc_bytes.push_back(8'($urandom_range(8'h8F, 8'h80)));
                else
                    doc_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
                doc_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
                doc_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end
            9:
                case ($urandom_range(2, 0))
                    0: doc_bytes.push_back(CH_DASH);
                    1: doc_bytes.push_back(CH_GT);
                    default: doc_bytes.push_back(CH_LT);
                endcase
            default:
                if ($urandom_range(3, 0) == 0)
                    doc_bytes.push_back(8'($urandom_range(8'h7F, 8'h00)));
                else
                    doc_bytes.push_back(8'(8'h61 + $urandom_range(25, 0)));
        endcase
    endfunction

    function automatic void add_tag();
        doc_bytes.push_back(CH_LT);
        case ($urandom_range(4, 0))
            0:
            begin
                doc_bytes.push_back(CH_SLASH);
                repeat ($urandom_range(4, 1))
                    doc_bytes.push_back(8'(8'h61 + $urandom_range(25, 0)));
            end
            1:
            begin
                if ($urandom_range(3, 0) == 0)
                    doc_bytes.push_back(CH_SLASH);
                doc_bytes.push_back(CH_BANG);
                doc_bytes.push_back(CH_DASH);
                doc_bytes.push_back(CH_DASH);
                repeat ($urandom_range(6, 0))
                    add_char();
                doc_bytes.push_back(CH_DASH);
                doc_bytes.push_back(CH_DASH);
            end
            2:
            begin
                doc_bytes.push_back(CH_BANG);
                doc_bytes.push_back(CH_DASH);
                doc_bytes.push_back(CH_DASH);
            end
            3:
            begin
                doc_bytes.push_back(CH_BANG);
                doc_bytes.push_back(CH_DASH);
                doc_bytes.push_back(CH_DASH);
                doc_bytes.push_back(8'(8'h61 + $urandom_range(25, 0)));
                repeat ($urandom_range(3, 0))
                    add_char();
            end
            default:
            begin
                repeat ($urandom_range(4, 1))
                    doc_bytes.push_back(8'(8'h61 + $urandom_range(25, 0)));
                repeat ($urandom_range(5, 0))
                    add_char();
            end
        endcase
        doc_bytes.push_back(CH_GT);
    endfunction

    // Mostly well-formed documents, some cut short and some with one random byte.
    function automatic void build_document();
        int pick;
        doc_bytes.delete();
        repeat ($urandom_range(5, 1))
        begin
            if ($urandom_range(1, 0) == 0)
                add_tag();
            else
                repeat ($urandom_range(6, 1))
                    add_char();
        end
        pick = $urandom_range(99, 0);
        if (pick < 10)
        begin
            pick = $urandom_range(doc_bytes.size(), 1);
            while (doc_bytes.size() > pick)
                void'(doc_bytes.pop_back());
        end
        else if (pick < 20)
            doc_bytes.insert($urandom_range(doc_bytes.size(), 0), 8'($urandom_range(255, 0)));
    endfunction

    task automatic send_document();
        build_document();
        for (int i = 0; i < doc_bytes.size(); i++)
            send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    endtask

    task automatic test_markup_kinds();
        send_text("a>b<<c>");
    endtask

    task automatic test_comment_close();
        send_text("<!--x>-->");
    endtask

    task automatic test_utf8_rules();
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hE0, 1'b1);
        send_text("z");
    endtask

    task automatic test_random_documents(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target)
            send_document();
    endtask

    task automatic test_output_stall();
        drain_tokens();
        hold_left = HOLD_CYCLES;
        @(posedge clk);
        repeat (4)
            send_document();
        drain_tokens();
        @(posedge clk);
    endtask

    initial
    begin
        rst_n                = 1'b0;
        byte_stream.valid    = 1'b0;
        byte_stream.payload  = '0;
        clear_lexer();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(33, 73);
        test_markup_kinds();
        test_comment_close();
        test_utf8_rules();
        test_random_documents(420);
        set_idling(73, 33);
        test_random_documents(420);
        set_idling(0, 0);
        test_random_documents(410);
        test_output_stall();

        drain_tokens();
        repeat (8) @(posedge clk);
        if (pending_tokens.size() != 0)
            note_error($sformatf("%0d tokens never arrived", pending_tokens.size()));
        $display("Sent %0d bytes in %0d documents and checked %0d tokens.",
                 bytes_sent, docs_sent, tokens_checked);
        $display("Covered three idling mixes, a long output stall and %0d mismatches.",
                 error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
